// ----- src/mfrw_pkg.sv -----
// Shared types, constants and helpers of the mono framebuffer region writer.
`timescale 1ns / 1ps
`default_nettype none

package mfrw_pkg;

  localparam int PANEL_WIDTH  = 528;
  localparam int PANEL_HEIGHT = 792;
  localparam int ROW_BYTES    = PANEL_WIDTH / 8;
  localparam int STORE_BYTES  = ROW_BYTES * PANEL_HEIGHT;
  localparam int STORE_AW     = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  // wide enough for row * ROW_BYTES + byte column and for any read address
  localparam int IDX_W        = 18;

  localparam int COORD_W   = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 10;

  localparam logic [COORD_W-1:0] XE_MAX = COORD_W'(PANEL_WIDTH - 1);
  localparam logic [COORD_W-1:0] YE_MAX = COORD_W'(PANEL_HEIGHT - 1);

  localparam logic [COORD_W-1:0] X_START_RST = 10'd0;
  localparam logic [COORD_W-1:0] Y_START_RST = 10'd0;
  localparam logic [COORD_W-1:0] X_END_RST   = 10'd527;
  localparam logic [COORD_W-1:0] Y_END_RST   = 10'd791;

  localparam logic [7:0] BYTE_WHITE = 8'hFF;
  localparam logic [7:0] BYTE_BLACK = 8'h00;
  localparam logic [9:0] GRAY_THRESH = 10'd126;

  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_CLEAR = 2'd1,
    FN_FILL  = 2'd2,
    FN_READ  = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_START = 3'd0,
    CFG_Y_START = 3'd1,
    CFG_X_END   = 3'd2,
    CFG_Y_END   = 3'd3,
    CFG_PACK    = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_CALC,
    ST_READ,
    ST_MOD
  } state_e;

  typedef struct packed {
    func_e       func;
    logic [7:0]  pixel_data;
    logic [15:0] read_address;
  } cmd_t;

  typedef struct packed {
    logic [7:0] rd_byte;
    logic       region_done;
    logic       rejected;
  } res_t;

  // region/cursor status seen by the controller
  typedef struct packed {
    logic               reject;
    logic               last;
    logic               pack;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } region_st_t;

  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [STORE_AW-1:0] raddr;
  } mem_req_t;

  // RGB332 to one bit: gray = r*36 + g*36 + b*64, white above threshold
  function automatic logic pix_white(input logic [7:0] pix);
    logic [9:0] r;
    logic [9:0] g;
    logic [9:0] b;
    logic [9:0] gray;
    r    = 10'(pix[7:5]);
    g    = 10'(pix[4:2]);
    b    = 10'(pix[1:0]);
    gray = (r + g) * 10'd36 + b * 10'd64;
    return gray > GRAY_THRESH;
  endfunction

endpackage

`default_nettype wire

// ----- src/mono_framebuffer_region_writer_core.sv -----
// Top level of the 1-bit-per-pixel framebuffer region writer.
//
// A command is taken when start is high and busy is low. After reset the block
// runs a clearing pass that writes white to all STORE_BYTES (52272) bytes, one
// per cycle, with busy high; register writes are taken during it. A region
// write or a byte read runs through accept, row-times-width address
// calculation, memory read, then write-back (for a write) with the result
// strobe, and then returns to idle for the next accept. Clear and fill sweep
// the store one byte per cycle and report in the last sweep cycle, then return
// to idle. Every command gives one result, shown for one cycle with
// result_valid_o; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module mono_framebuffer_region_writer_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire mfrw_pkg::cmd_t                 cmd_i,
  output logic                                result_valid_o,
  output mfrw_pkg::res_t                      result_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [mfrw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [mfrw_pkg::CFG_W-1:0]     cfg_wdata_i
);

  mfrw_pkg::region_st_t region_st;
  mfrw_pkg::mem_req_t   mem_req;
  logic                 advance;
  logic [7:0]           rdata;

  mfrw_region u_region (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (advance),
    .st_o        (region_st)
  );

  mfrw_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  mfrw_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .st_i           (region_st),
    .advance_o      (advance),
    .mem_o          (mem_req),
    .rdata_i        (rdata)
  );

endmodule

`default_nettype wire

// ----- src/mfrw_ram.sv -----
// Framebuffer byte store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mfrw_ram (
  input  wire logic              clk_i,
  input  wire mfrw_pkg::mem_req_t req_i,
  output logic [7:0]             rdata_o
);

  logic [7:0] mem_q [mfrw_pkg::STORE_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/mfrw_region.sv -----
// Region registers, end clamping and the raster cursor.
`timescale 1ns / 1ps
`default_nettype none

module mfrw_region (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [mfrw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [mfrw_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  wire logic                             advance_i,
  output mfrw_pkg::region_st_t                  st_o
);

  logic [mfrw_pkg::COORD_W-1:0] x_start_q, x_start_d;
  logic [mfrw_pkg::COORD_W-1:0] y_start_q, y_start_d;
  logic [mfrw_pkg::COORD_W-1:0] x_end_q, x_end_d;
  logic [mfrw_pkg::COORD_W-1:0] y_end_q, y_end_d;
  logic                         pack_q, pack_d;
  logic [mfrw_pkg::COORD_W-1:0] col_q, col_d;
  logic [mfrw_pkg::COORD_W-1:0] row_q, row_d;

  logic [mfrw_pkg::COORD_W-1:0] xe, ye;
  logic [6:0]                   bcol;
  logic                         row_end, last, home;

  assign xe = ({1'b0, x_end_q} >= 11'(mfrw_pkg::PANEL_WIDTH)) ? mfrw_pkg::XE_MAX : x_end_q;
  assign ye = ({1'b0, y_end_q} >= 11'(mfrw_pkg::PANEL_HEIGHT)) ? mfrw_pkg::YE_MAX : y_end_q;

  assign bcol    = col_q[9:3];
  assign row_end = pack_q ? (bcol >= xe[9:3]) : (col_q >= xe);
  assign last    = row_end && (row_q >= ye);

  assign st_o.reject = (x_start_q > xe) || (y_start_q > ye);
  assign st_o.last   = last;
  assign st_o.pack   = pack_q;
  assign st_o.col    = col_q;
  assign st_o.row    = row_q;

  always_comb begin
    x_start_d = x_start_q;
    y_start_d = y_start_q;
    x_end_d   = x_end_q;
    y_end_d   = y_end_q;
    pack_d    = pack_q;
    col_d     = col_q;
    row_d     = row_q;
    home      = 1'b0;
    if (cfg_we_i) begin
      unique case (mfrw_pkg::cfg_idx_e'(cfg_idx_i))
        mfrw_pkg::CFG_X_START: begin
          x_start_d = cfg_wdata_i;
          home      = 1'b1;
        end
        mfrw_pkg::CFG_Y_START: begin
          y_start_d = cfg_wdata_i;
          home      = 1'b1;
        end
        mfrw_pkg::CFG_X_END: begin
          x_end_d = cfg_wdata_i;
          home    = 1'b1;
        end
        mfrw_pkg::CFG_Y_END: begin
          y_end_d = cfg_wdata_i;
          home    = 1'b1;
        end
        mfrw_pkg::CFG_PACK: begin
          pack_d = cfg_wdata_i[0];
          home   = 1'b1;
        end
        default: ;
      endcase
      if (home) begin
        col_d = x_start_d;
        row_d = y_start_d;
      end
    end else if (advance_i) begin
      if (!row_end) begin
        col_d = pack_q ? {7'(bcol + 7'd1), 3'b000} : col_q + 10'd1;
      end else begin
        col_d = x_start_q;
        row_d = last ? y_start_q : row_q + 10'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_start_q <= mfrw_pkg::X_START_RST;
      y_start_q <= mfrw_pkg::Y_START_RST;
      x_end_q   <= mfrw_pkg::X_END_RST;
      y_end_q   <= mfrw_pkg::Y_END_RST;
      pack_q    <= 1'b0;
      col_q     <= mfrw_pkg::X_START_RST;
      row_q     <= mfrw_pkg::Y_START_RST;
    end else begin
      x_start_q <= x_start_d;
      y_start_q <= y_start_d;
      x_end_q   <= x_end_d;
      y_end_q   <= y_end_d;
      pack_q    <= pack_d;
      col_q     <= col_d;
      row_q     <= row_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/mfrw_ctrl.sv -----
// Command sequencer: memory sweeps, address calculation, read-modify-write.
`timescale 1ns / 1ps
`default_nettype none

module mfrw_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire mfrw_pkg::cmd_t       cmd_i,
  output logic                      result_valid_o,
  output mfrw_pkg::res_t            result_o,
  input  wire mfrw_pkg::region_st_t st_i,
  output logic                      advance_o,
  output mfrw_pkg::mem_req_t        mem_o,
  input  wire logic [7:0]           rdata_i
);

  mfrw_pkg::state_e             state_q, state_d;
  mfrw_pkg::cmd_t               cmd_q, cmd_d;
  logic [mfrw_pkg::STORE_AW-1:0] sweep_q, sweep_d;
  logic [7:0]                   fill_q, fill_d;
  logic                         report_q, report_d;
  logic [mfrw_pkg::STORE_AW-1:0] idx_q, idx_d;
  logic                         in_range_q, in_range_d;
  logic                         reject_q, reject_d;

  logic [mfrw_pkg::IDX_W-1:0]   idx_full;
  logic [7:0]                   mask;
  logic                         is_write;

  assign busy_o   = (state_q != mfrw_pkg::ST_IDLE);
  assign is_write = (cmd_q.func == mfrw_pkg::FN_WRITE);
  assign mask     = 8'h80 >> st_i.col[2:0];

  always_comb begin
    if (cmd_q.func == mfrw_pkg::FN_READ) begin
      idx_full = mfrw_pkg::IDX_W'(cmd_q.read_address);
    end else begin
      idx_full = mfrw_pkg::IDX_W'(st_i.row) * mfrw_pkg::IDX_W'(mfrw_pkg::ROW_BYTES)
               + mfrw_pkg::IDX_W'(st_i.col[9:3]);
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_d          = cmd_q;
    sweep_d        = sweep_q;
    fill_d         = fill_q;
    report_d       = report_q;
    idx_d          = idx_q;
    in_range_d     = in_range_q;
    reject_d       = reject_q;
    result_valid_o = 1'b0;
    result_o       = '0;
    advance_o      = 1'b0;
    mem_o          = '0;
    unique case (state_q)
      mfrw_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_d = cmd_i;
          unique case (cmd_i.func)
            mfrw_pkg::FN_CLEAR, mfrw_pkg::FN_FILL: begin
              fill_d   = (cmd_i.func == mfrw_pkg::FN_CLEAR) ? mfrw_pkg::BYTE_WHITE
                                                             : mfrw_pkg::BYTE_BLACK;
              sweep_d  = '0;
              report_d = 1'b1;
              state_d  = mfrw_pkg::ST_SWEEP;
            end
            default: state_d = mfrw_pkg::ST_CALC;
          endcase
        end
      end
      mfrw_pkg::ST_SWEEP: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = sweep_q;
        mem_o.wdata = fill_q;
        if (sweep_q == mfrw_pkg::STORE_AW'(mfrw_pkg::STORE_BYTES - 1)) begin
          // the power-on pass ends without a transaction
          result_valid_o = report_q;
          report_d       = 1'b0;
          state_d        = mfrw_pkg::ST_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      mfrw_pkg::ST_CALC: begin
        idx_d      = idx_full[mfrw_pkg::STORE_AW-1:0];
        in_range_d = idx_full < mfrw_pkg::IDX_W'(mfrw_pkg::STORE_BYTES);
        reject_d   = is_write && st_i.reject;
        state_d    = mfrw_pkg::ST_READ;
      end
      mfrw_pkg::ST_READ: begin
        mem_o.re    = in_range_q && !reject_q;
        mem_o.raddr = idx_q;
        state_d     = mfrw_pkg::ST_MOD;
      end
      mfrw_pkg::ST_MOD: begin
        result_valid_o = 1'b1;
        if (is_write) begin
          result_o.rejected    = reject_q;
          result_o.region_done = !reject_q && st_i.last;
          advance_o            = !reject_q;
          mem_o.we             = !reject_q && in_range_q;
          mem_o.waddr          = idx_q;
          if (st_i.pack) begin
            mem_o.wdata = cmd_q.pixel_data;
          end else if (mfrw_pkg::pix_white(cmd_q.pixel_data)) begin
            mem_o.wdata = rdata_i | mask;
          end else begin
            mem_o.wdata = rdata_i & ~mask;
          end
        end else begin
          result_o.rd_byte = in_range_q ? rdata_i : 8'h00;
        end
        state_d = mfrw_pkg::ST_IDLE;
      end
      default: state_d = mfrw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mfrw_pkg::ST_SWEEP;
      sweep_q  <= '0;
      fill_q   <= mfrw_pkg::BYTE_WHITE;
      report_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sweep_q  <= sweep_d;
      fill_q   <= fill_d;
      report_q <= report_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    idx_q      <= idx_d;
    in_range_q <= in_range_d;
    reject_q   <= reject_d;
  end

endmodule

`default_nettype wire
